### hdl/button_click_classifier_assert.svh
// Assertion macros for the button click classifier.
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("button_click_classifier: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("button_click_classifier: assertion failed");

`endif

### hdl/bcc_pkg.sv
package bcc_pkg;

    // Width of the tick counter and all time stamps
    localparam int TIME_WIDTH = 32;

    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int DUR_WIDTH     = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DBL_WIN  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_HOLD     = 2'd2;

    // Reset values of the registers
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_WIDTH-1:0] DBL_WIN_RST  = 16'd250;
    localparam logic [CFG_WIDTH-1:0] HOLD_RST     = 16'd1000;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_HOLD   = 2'd3
    } t_event_code;

    typedef logic [TIME_WIDTH-1:0] t_time;

    typedef struct packed {
        t_event_code          code;
        logic [DUR_WIDTH-1:0] dur;
    } t_result;

endpackage

### hdl/button_click_classifier.sv
// Button click classifier.
// Input channel: one request per tick carries the sampled button level
// (i_in_valid / o_in_stall / i_button_level). Each accepted request
// advances the internal tick counter by one.
// Output channel: one result per request (o_out_valid / i_out_stall /
// o_event_code, o_press_duration): 0 none, 1 click, 2 double click, 3 hold,
// plus the length of the last completed press in ticks.
// Each result is registered into the result register, or into the skid
// register while the receiver stalls the result register. Throughput: one
// request per cycle unless o_in_stall is high; the classifier state is
// updated in the accepting cycle by a few subtract/compare paths on 32-bit
// stamps. This two-entry buffer keeps the input open while a result waits;
// o_in_stall rises only when both are full (a request taken during a stall).
// Configuration: i_cfg_we writes register i_cfg_index (0 debounce,
// 1 double-click window, 2 hold threshold), low 16 bits of i_cfg_data.
// Index 3 is ignored. Write only while no request is in flight.
// Reset (synchronous, active low): counter and stamps cleared, gap set to
// all ones, registers back to 50 / 250 / 1000, both buffer entries empty.
`include "button_click_classifier_assert.svh"

module button_click_classifier
    import bcc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_button_level,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_event_code,
    output logic [DUR_WIDTH-1:0]     o_press_duration
);

    // configuration registers
    logic [CFG_WIDTH-1:0] r_debounce;
    logic [CFG_WIDTH-1:0] r_dbl_win;
    logic [CFG_WIDTH-1:0] r_hold;

    // classifier state
    t_time       r_tick, n_tick;
    t_time       r_release_time, n_release_time;
    t_time       r_press_time, n_press_time;
    t_time       r_gap_time, n_gap_time;
    t_time       r_held_time, n_held_time;
    logic        r_level_latched, n_level_latched;
    logic        r_click_done, n_click_done;
    logic        r_released_once, n_released_once;
    t_event_code r_event, n_event;

    // output buffer
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    logic    in_fire;
    logic    out_fire;
    t_time   since_release;
    t_time   since_press;
    t_time   debounce_t;
    logic    press_edge;
    logic    release_edge;
    t_result new_result;

    assign in_fire  = i_in_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_out_stall;

    // elapsed times wrap modulo the counter width
    assign since_release = r_tick - r_release_time;
    assign since_press   = r_tick - r_press_time;
    assign debounce_t    = TIME_WIDTH'(r_debounce);

    // press wins; release only considered when no press on this tick
    assign press_edge   = i_button_level && !r_level_latched && (since_release > debounce_t);
    assign release_edge = !i_button_level && r_level_latched && (since_press > debounce_t);

    always_comb begin
        n_tick          = r_tick + 1'b1;
        n_release_time  = r_release_time;
        n_press_time    = r_press_time;
        n_gap_time      = r_gap_time;
        n_held_time     = r_held_time;
        n_level_latched = r_level_latched;
        n_click_done    = r_click_done;
        n_released_once = r_released_once;
        n_event         = r_event;

        if (press_edge) begin
            // the gap counts only once a full click has been seen
            if (r_released_once && r_click_done) begin
                n_gap_time = since_release;
            end
            n_press_time    = r_tick;
            n_level_latched = 1'b1;
            n_event         = EV_NONE;
            n_click_done    = 1'b0;
        end else if (release_edge) begin
            n_release_time  = r_tick;
            n_held_time     = since_press;
            n_released_once = 1'b1;
            n_click_done    = 1'b1;
            n_level_latched = 1'b0;
        end

        // classify; hold overrides double, an existing code is kept otherwise
        if (n_click_done) begin
            if (n_released_once && (n_gap_time < TIME_WIDTH'(r_dbl_win))) begin
                n_event = EV_DOUBLE;
            end
            if (n_held_time > TIME_WIDTH'(r_hold)) begin
                n_event = EV_HOLD;
            end
            if (n_event == EV_NONE) begin
                n_event = EV_CLICK;
            end
        end
    end

    assign new_result.code = n_event;
    assign new_result.dur  = DUR_WIDTH'(n_held_time);

    // result register with skid entry behind it
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (in_fire) begin
                n_out       = new_result;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_fire) begin
            // receiver stalled: park the new result
            n_skid       = new_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_dbl_win  <= DBL_WIN_RST;
            r_hold     <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_DBL_WIN:  r_dbl_win  <= i_cfg_data;
                CFG_HOLD:     r_hold     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick          <= '0;
            r_release_time  <= '0;
            r_press_time    <= '0;
            r_gap_time      <= '1;
            r_held_time     <= '0;
            r_level_latched <= 1'b0;
            r_click_done    <= 1'b0;
            r_released_once <= 1'b0;
            r_event         <= EV_NONE;
        end else if (in_fire) begin
            r_tick          <= n_tick;
            r_release_time  <= n_release_time;
            r_press_time    <= n_press_time;
            r_gap_time      <= n_gap_time;
            r_held_time     <= n_held_time;
            r_level_latched <= n_level_latched;
            r_click_done    <= n_click_done;
            r_released_once <= n_released_once;
            r_event         <= n_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_stall       = r_skid_valid;
    assign o_out_valid      = r_out_valid;
    assign o_event_code     = r_out.code;
    assign o_press_duration = r_out.dur;

    // skid entry is only used behind a full result register
    `BCC_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // a request taken while the result is stalled lands in the skid entry
    `BCC_ASSERT_NEXT(a_stall_to_skid, i_clk, i_rst_n,
        r_out_valid && i_out_stall && in_fire, r_skid_valid)
    // a latched press never coexists with a completed click
    `BCC_ASSERT_NOW(a_press_not_done, i_clk, i_rst_n, r_level_latched, !r_click_done)
    // a completed click always carries a classification
    `BCC_ASSERT_NOW(a_done_has_event, i_clk, i_rst_n, r_click_done, r_event != EV_NONE)

endmodule

### tb/sv/button_click_classifier_chk.sv
`timescale 1ns / 100ps

// Watches both channels and the config port. Keeps its own copy of the
// classifier state, predicts one result per accepted request and compares
// results in order.
module button_click_classifier_chk
    import bcc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic                     i_button_level,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic [1:0]               i_event_code,
    input  logic [DUR_WIDTH-1:0]     i_press_duration,
    output int                       o_pending,
    output int                       o_errors
);

    logic [CFG_WIDTH-1:0] debounce;
    logic [CFG_WIDTH-1:0] dbl_window;
    logic [CFG_WIDTH-1:0] hold_limit;

    t_time       tick_now;
    t_time       last_release;
    t_time       last_press;
    t_time       gap;
    t_time       held;
    logic        pressed;
    logic        click_seen;
    logic        any_release;
    t_event_code cur_event;

    t_result awaited_events[$];
    t_result oldest;

    // One tick of the classifier; queues the result it produces.
    function automatic void classify_tick(input logic lvl);
        t_time   since_rel;
        t_time   since_prs;
        t_result res;
        since_rel = tick_now - last_release;
        since_prs = tick_now - last_press;
        if (lvl && !pressed && since_rel > t_time'(debounce)) begin
            if (any_release && click_seen)
                gap = since_rel;
            last_press = tick_now;
            pressed    = 1'b1;
            cur_event  = EV_NONE;
            click_seen = 1'b0;
        end else if (!lvl && pressed && since_prs > t_time'(debounce)) begin
            last_release = tick_now;
            held         = since_prs;
            any_release  = 1'b1;
            click_seen   = 1'b1;
            pressed      = 1'b0;
        end
        if (click_seen) begin
            if (any_release && gap < t_time'(dbl_window))
                cur_event = EV_DOUBLE;
            // hold wins over double click
            if (held > t_time'(hold_limit))
                cur_event = EV_HOLD;
            if (cur_event == EV_NONE)
                cur_event = EV_CLICK;
        end
        tick_now = tick_now + 1'b1;
        res.code = cur_event;
        res.dur  = held[DUR_WIDTH-1:0];
        awaited_events.push_back(res);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            debounce     = DEBOUNCE_RST;
            dbl_window   = DBL_WIN_RST;
            hold_limit   = HOLD_RST;
            tick_now     = '0;
            last_release = '0;
            last_press   = '0;
            gap          = '1;
            held         = '0;
            pressed      = 1'b0;
            click_seen   = 1'b0;
            any_release  = 1'b0;
            cur_event    = EV_NONE;
            awaited_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE: debounce   = i_cfg_data;
                    CFG_DBL_WIN:  dbl_window = i_cfg_data;
                    CFG_HOLD:     hold_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                classify_tick(i_button_level);
            if (i_out_valid && !i_out_stall) begin
                if (awaited_events.size() == 0) begin
                    $error("result with no request outstanding: code %0d, duration %0d",
                           i_event_code, i_press_duration);
                    o_errors++;
                end else begin
                    oldest = awaited_events.pop_front();
                    if (i_event_code !== oldest.code) begin
                        $error("event_code mismatch: expected %0d, actual %0d",
                               oldest.code, i_event_code);
                        o_errors++;
                    end
                    if (i_press_duration !== oldest.dur) begin
                        $error("press_duration mismatch: expected %0d, actual %0d",
                               oldest.dur, i_press_duration);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = awaited_events.size();
    end

endmodule

### tb/sv/button_click_classifier_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the button click classifier. Each request is one
// tick of the button level. Presses and releases are built as runs of equal
// levels whose lengths sit around the debounce, double-click and hold limits
// of the current setting, so edges get both accepted and rejected. The
// checker beside the block does all prediction and comparison.
module button_click_classifier_tb;
    import bcc_pkg::*;

    // register index the block has no register for
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED = 2'd3;

    // longest run of one level; keeps long settings from dominating the run
    localparam int RUN_CAP = 300;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]     cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     button_level;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               event_code;
    logic [DUR_WIDTH-1:0]     press_duration;

    int pending;
    int errors;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int ticks_sent    = 0;

    always #4 clk = ~clk;

    button_click_classifier i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_button_level   (button_level),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_event_code     (event_code),
        .o_press_duration (press_duration)
    );

    button_click_classifier_chk u_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_button_level   (button_level),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_event_code     (event_code),
        .i_press_duration (press_duration),
        .o_pending        (pending),
        .o_errors         (errors)
    );

    // Receiver side: random stall at the rate of the current idling mode.
    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(0, 99) < out_stall_pct);
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_SEND: begin in_idle_pct = 56; out_stall_pct = 0;  end
            IDLE_RECV: begin in_idle_pct = 0;  out_stall_pct = 56; end
            IDLE_BOTH: begin in_idle_pct = 15; out_stall_pct = 15; end
            default:   begin in_idle_pct = 0;  out_stall_pct = 0;  end
        endcase
    endtask

    // One request: optional idle cycles (level wanders while not valid),
    // then hold valid until the block takes it. Returns at the accepting edge.
    task automatic send_tick(input logic lvl);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid     <= 1'b0;
            button_level <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        button_level <= lvl;
        do
            @(posedge clk);
        while (in_stall);
        ticks_sent++;
    endtask

    // Run of one level, cut short once the phase budget is used up.
    task automatic send_run(input logic lvl, input int len, input int stop_at);
        for (int i = 0; i < len && ticks_sent < stop_at; i++)
            send_tick(lvl);
    endtask

    // Fixed patterns, sent oldest bit first (MSB).
    task automatic send_pattern(input logic [31:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--)
            send_tick(bits[i]);
    endtask

    // Run length near the interesting limits: just under/over debounce,
    // straddling the threshold, or anywhere between.
    function automatic int pick_len(input int db, input int thr);
        int len;
        case ($urandom_range(0, 3))
            0:       len = $urandom_range(1, db + 1);
            1:       len = $urandom_range((thr > 1) ? thr - 1 : 1, thr + 2);
            2:       len = $urandom_range(db + 1, db + 1 + thr);
            default: len = $urandom_range(1, 2 * db + 3);
        endcase
        if (len > RUN_CAP)
            len = $urandom_range(1, RUN_CAP);
        return len;
    endfunction

    // Drain every outstanding result, then write all registers plus the
    // unused index (must be ignored). Called at a rising edge.
    task automatic configure(input int db, input int win, input int hold);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= CFG_WIDTH'(db);
        @(posedge clk);
        cfg_index <= CFG_DBL_WIN;
        cfg_data  <= CFG_WIDTH'(win);
        @(posedge clk);
        cfg_index <= CFG_HOLD;
        cfg_data  <= CFG_WIDTH'(hold);
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= CFG_WIDTH'($urandom_range(0, 65535));
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly press/release pairs with random lengths, some raw noise.
    task automatic run_phase(input int db, input int win, input int hold,
                             input int budget, input t_idle_mode mode);
        int stop_at;
        configure(db, win, hold);
        set_idling(mode);
        stop_at = ticks_sent + budget;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(0, 99) < 12) begin
                repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
            end else begin
                send_run(1'b1, pick_len(db, hold), stop_at);
                send_run(1'b0, pick_len(db, win), stop_at);
            end
        end
    endtask

    initial begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_DEBOUNCE;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        button_level <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, no idling.
        // No debounce, widest window, hold never: first click right after
        // reset is a plain click (gap unmeasured), the next one a double.
        configure(0, 65535, 65535);
        send_pattern(32'b1110_0100, 8);
        // Debounce 3, window 0, hold 0: press rejected until more than
        // 3 ticks after the release, a short release glitch is ignored,
        // any completed press is a hold.
        configure(3, 0, 0);
        send_pattern(32'b1_1110_1110, 9);
        // Widest debounce: no edge gets through, result just repeats.
        configure(65535, 100, 5);
        send_pattern(32'b11_0010, 6);

        // Random part: extreme settings first, reset values, then random
        // small ones so every boundary is hit often.
        run_phase(0, 65535, 10, 90, IDLE_NONE);
        run_phase(2, 0, 65535, 90, IDLE_SEND);
        run_phase(1, 12, 0, 90, IDLE_RECV);
        run_phase(DEBOUNCE_RST, DBL_WIN_RST, HOLD_RST, 250, IDLE_BOTH);
        for (int i = 0; i < 6; i++)
            run_phase($urandom_range(0, 6), $urandom_range(0, 40), $urandom_range(0, 40),
                      90, t_idle_mode'(i % 4));

        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("button_click_classifier_tb passed");
        else
            $display("button_click_classifier_tb failed");
        $finish;
    end

    // Run-away guard, several times the slowest legal run.
    initial begin
        #(5_000_000);
        $display("button_click_classifier_tb failed");
        $finish;
    end

endmodule
